FILE: rtl/core/laqg_pkg.sv
// Shared types and constants for the load adaptive quality governor.
package laqg_pkg;

	// Action codes reported with each result item.
	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_PROF_DOWN = 3'd1,
		ACT_PROF_UP   = 3'd2,
		ACT_Q_DOWN    = 3'd3,
		ACT_Q_UP      = 3'd4
	} action_t;

	// Profile codes; code 3 means an unknown profile.
	localparam logic [1:0] PROF_240 = 2'd0;
	localparam logic [1:0] PROF_480 = 2'd1;
	localparam logic [1:0] PROF_720 = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_CPU_HIGH  = 3'd0;
	localparam logic [2:0] REG_CPU_LOW   = 3'd1;
	localparam logic [2:0] REG_BL_HIGH   = 3'd2;
	localparam logic [2:0] REG_BL_LOW    = 3'd3;
	localparam logic [2:0] REG_GUARD     = 3'd4;
	localparam logic [2:0] REG_Q_MIN     = 3'd5;
	localparam logic [2:0] REG_Q_MAX     = 3'd6;
	localparam logic [2:0] REG_Q_STEP    = 3'd7;

	// Register reset values.
	localparam logic [6:0]  RST_CPU_HIGH = 7'd85;
	localparam logic [6:0]  RST_CPU_LOW  = 7'd55;
	localparam logic [7:0]  RST_BL_HIGH  = 8'd3;
	localparam logic [7:0]  RST_BL_LOW   = 8'd2;
	localparam logic [31:0] RST_GUARD    = 32'd10000000;
	localparam logic [6:0]  RST_Q_MIN    = 7'd50;
	localparam logic [6:0]  RST_Q_MAX    = 7'd90;
	localparam logic [6:0]  RST_Q_STEP   = 7'd5;

	// Configuration register set.
	typedef struct packed {
		logic [6:0]  cpu_high_pct;
		logic [6:0]  cpu_low_pct;
		logic [7:0]  backlog_high;
		logic [7:0]  backlog_low;
		logic [31:0] guard_time_us;
		logic [6:0]  quality_min;
		logic [6:0]  quality_max;
		logic [6:0]  quality_step;
	} cfg_t;

	// Outcome of one evaluation, including the shift time updates.
	typedef struct packed {
		logic [1:0] profile;
		logic [6:0] quality;
		logic       profile_changed;
		logic       quality_changed;
		action_t    action;
		logic       set_down_time;
		logic       set_up_time;
	} decision_t;

endpackage

FILE: rtl/core/laqg_decide.sv
// Decision logic for one evaluation item: load classification and shift choice.
module laqg_decide
	import laqg_pkg::*;
(
	input  cfg_t        cfg,
	input  logic [7:0]  cpu_load,
	input  logic [31:0] frames_accepted,
	input  logic [31:0] frames_served,
	input  logic [63:0] time_now_us,
	input  logic [1:0]  current_profile,
	input  logic [6:0]  current_quality,
	input  logic [63:0] last_down_time,
	input  logic [63:0] last_up_time,
	output decision_t   dec
);

	logic        backlog_pos;
	logic [31:0] backlog;
	logic        load_high;
	logic        load_low;
	logic [63:0] since_down;
	logic [63:0] since_up;
	logic        guard_ok;
	logic signed [8:0] q_down;
	logic signed [8:0] q_up;
	logic signed [8:0] q_raw;
	logic signed [8:0] q_min_s;
	logic signed [8:0] q_max_s;
	logic [6:0]  q_clamped;

	// Backlog, floored at zero, and load classification.
	assign backlog_pos = frames_accepted > frames_served;
	assign backlog     = backlog_pos ? (frames_accepted - frames_served) : 32'd0;
	assign load_high   = (cpu_load > {1'b0, cfg.cpu_high_pct}) ||
		(backlog > {24'd0, cfg.backlog_high});
	assign load_low    = (cpu_load < {1'b0, cfg.cpu_low_pct}) &&
		(backlog < {24'd0, cfg.backlog_low});

	// Elapsed time since each shift wraps modulo 2^64.
	assign since_down = time_now_us - last_down_time;
	assign since_up   = time_now_us - last_up_time;
	assign guard_ok   = (since_down > {32'd0, cfg.guard_time_us}) &&
		(since_up > {32'd0, cfg.guard_time_us});

	// Quality step taken as a signed value, then clamped to the limits.
	assign q_down  = $signed({2'b00, current_quality}) - $signed({2'b00, cfg.quality_step});
	assign q_up    = $signed({2'b00, current_quality}) + $signed({2'b00, cfg.quality_step});
	assign q_raw   = load_high ? q_down : q_up;
	assign q_min_s = $signed({2'b00, cfg.quality_min});
	assign q_max_s = $signed({2'b00, cfg.quality_max});

	always_comb begin
		if (q_raw < q_min_s) begin
			q_clamped = cfg.quality_min;
		end else if (q_raw > q_max_s) begin
			q_clamped = cfg.quality_max;
		end else begin
			q_clamped = q_raw[6:0];
		end
	end

	// Choose the action: a profile rung if one is available, else a quality step.
	always_comb begin
		dec.profile       = current_profile;
		dec.quality       = current_quality;
		dec.action        = ACT_NONE;
		dec.set_down_time = 1'b0;
		dec.set_up_time   = 1'b0;
		if (load_high) begin
			case (current_profile)
				PROF_720: begin
					dec.profile       = PROF_480;
					dec.action        = ACT_PROF_DOWN;
					dec.set_down_time = 1'b1;
				end
				PROF_480: begin
					dec.profile       = PROF_240;
					dec.action        = ACT_PROF_DOWN;
					dec.set_down_time = 1'b1;
				end
				default: begin
					dec.quality = q_clamped;
					dec.action  = ACT_Q_DOWN;
				end
			endcase
		end else if (load_low && guard_ok) begin
			case (current_profile)
				PROF_240: begin
					dec.profile     = PROF_480;
					dec.action      = ACT_PROF_UP;
					dec.set_up_time = 1'b1;
				end
				PROF_480: begin
					dec.profile     = PROF_720;
					dec.action      = ACT_PROF_UP;
					dec.set_up_time = 1'b1;
				end
				default: begin
					dec.quality = q_clamped;
					dec.action  = ACT_Q_UP;
				end
			endcase
		end
		dec.profile_changed = dec.profile != current_profile;
		dec.quality_changed = dec.quality != current_quality;
	end

endmodule

FILE: rtl/core/load_adaptive_quality_governor.sv
// Top level of the load adaptive quality governor: registers, pipeline and handshakes.
// An accepted input item is held in the input register and then in the result register.
// Throughput: one item per cycle while out_stall is low; the decision is one pass of logic
// between the two registers, and the shift times update as the item passes.
// Reset clears the pipeline valids and both shift times and loads the register defaults.
module load_adaptive_quality_governor
	import laqg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	// Input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  cpu_load,
	input  logic [31:0] frames_accepted,
	input  logic [31:0] frames_served,
	input  logic [63:0] time_now_us,
	input  logic [1:0]  current_profile,
	input  logic [6:0]  current_quality,
	// Output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  new_profile,
	output logic [6:0]  new_quality,
	output logic        profile_changed,
	output logic        quality_changed,
	output logic [2:0]  action_taken
);

	cfg_t        cfg_q;
	logic [63:0] last_down_q;
	logic [63:0] last_up_q;

	logic        valid_s1;
	logic [7:0]  load_s1;
	logic [31:0] acc_s1;
	logic [31:0] srv_s1;
	logic [63:0] time_s1;
	logic [1:0]  prof_s1;
	logic [6:0]  qual_s1;

	logic        valid_s2;
	decision_t   res_s2;

	decision_t   dec;
	logic        advance;
	logic        in_take;
	logic        move;

	// Pipeline control: the result register frees up when it is empty or taken.
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;
	assign move     = valid_s1 && advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cpu_high_pct  <= RST_CPU_HIGH;
			cfg_q.cpu_low_pct   <= RST_CPU_LOW;
			cfg_q.backlog_high  <= RST_BL_HIGH;
			cfg_q.backlog_low   <= RST_BL_LOW;
			cfg_q.guard_time_us <= RST_GUARD;
			cfg_q.quality_min   <= RST_Q_MIN;
			cfg_q.quality_max   <= RST_Q_MAX;
			cfg_q.quality_step  <= RST_Q_STEP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CPU_HIGH: cfg_q.cpu_high_pct  <= cfg_wdata[6:0];
				REG_CPU_LOW:  cfg_q.cpu_low_pct   <= cfg_wdata[6:0];
				REG_BL_HIGH:  cfg_q.backlog_high  <= cfg_wdata[7:0];
				REG_BL_LOW:   cfg_q.backlog_low   <= cfg_wdata[7:0];
				REG_GUARD:    cfg_q.guard_time_us <= cfg_wdata;
				REG_Q_MIN:    cfg_q.quality_min   <= cfg_wdata[6:0];
				REG_Q_MAX:    cfg_q.quality_max   <= cfg_wdata[6:0];
				REG_Q_STEP:   cfg_q.quality_step  <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	// Input register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			load_s1 <= cpu_load;
			acc_s1  <= frames_accepted;
			srv_s1  <= frames_served;
			time_s1 <= time_now_us;
			prof_s1 <= current_profile;
			qual_s1 <= current_quality;
		end
	end

	laqg_decide u_decide (
		.cfg             (cfg_q),
		.cpu_load        (load_s1),
		.frames_accepted (acc_s1),
		.frames_served   (srv_s1),
		.time_now_us     (time_s1),
		.current_profile (prof_s1),
		.current_quality (qual_s1),
		.last_down_time  (last_down_q),
		.last_up_time    (last_up_q),
		.dec             (dec)
	);

	// Shift times update as the item passes into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_down_q <= '0;
			last_up_q   <= '0;
		end else if (move) begin
			if (dec.set_down_time) begin
				last_down_q <= time_s1;
			end
			if (dec.set_up_time) begin
				last_up_q <= time_s1;
			end
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (move) begin
			res_s2 <= dec;
		end
	end

	assign out_valid       = valid_s2;
	assign new_profile     = res_s2.profile;
	assign new_quality     = res_s2.quality;
	assign profile_changed = res_s2.profile_changed;
	assign quality_changed = res_s2.quality_changed;
	assign action_taken    = res_s2.action;

	// A profile change is reported exactly when a profile action was taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.profile_changed ==
			(res_s2.action == ACT_PROF_DOWN || res_s2.action == ACT_PROF_UP)))
		else $error("profile_changed disagrees with action");

	// Without a quality action the quality passes through unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.action != ACT_Q_DOWN && res_s2.action != ACT_Q_UP)
			|-> !res_s2.quality_changed)
		else $error("quality changed without a quality action");

	// A downshift records the item's time.
	assert property (@(posedge clk) disable iff (!arst_n)
		(move && dec.action == ACT_PROF_DOWN) |=> (last_down_q == $past(time_s1)))
		else $error("downshift time not recorded");

	// An upshift records the item's time and leaves the downshift time alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		(move && dec.action == ACT_PROF_UP) |=>
			(last_up_q == $past(time_s1) && $stable(last_down_q)))
		else $error("upshift time update wrong");

	// The input side only stalls while the input register holds an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("stall with empty input register");

endmodule

FILE: tb/load_adaptive_quality_governor_tb.sv
// Self-checking testbench for the load adaptive quality governor: directed ticks, then random phases.
`timescale 1ns / 100ps

module load_adaptive_quality_governor_tb;
	import laqg_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;

	// One evaluation tick as presented on the input channel.
	typedef struct packed {
		logic [7:0]  cpu_load;
		logic [31:0] frames_accepted;
		logic [31:0] frames_served;
		logic [63:0] time_now_us;
		logic [1:0]  current_profile;
		logic [6:0]  current_quality;
	} tick_t;

	// The decision expected back for one tick.
	typedef struct packed {
		logic [1:0] new_profile;
		logic [6:0] new_quality;
		logic       profile_changed;
		logic       quality_changed;
		action_t    action;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_CPU_HIGH;
	logic [31:0] cfg_wdata = 32'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  cpu_load = 8'd0;
	logic [31:0] frames_accepted = 32'd0;
	logic [31:0] frames_served = 32'd0;
	logic [63:0] time_now_us = 64'd0;
	logic [1:0]  current_profile = PROF_240;
	logic [6:0]  current_quality = 7'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  new_profile;
	logic [6:0]  new_quality;
	logic        profile_changed;
	logic        quality_changed;
	logic [2:0]  action_taken;

	// Mirror of the register set and the shift times held by the block.
	cfg_t        settings = '{RST_CPU_HIGH, RST_CPU_LOW, RST_BL_HIGH, RST_BL_LOW, RST_GUARD,
		RST_Q_MIN, RST_Q_MAX, RST_Q_STEP};
	logic [63:0] last_down_us = 64'd0;
	logic [63:0] last_up_us = 64'd0;

	verdict_t    pending_verdicts[$];
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned calm_left = 0;
	logic [63:0] stim_time_us = 64'd0;

	load_adaptive_quality_governor dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cpu_load        (cpu_load),
		.frames_accepted (frames_accepted),
		.frames_served   (frames_served),
		.time_now_us     (time_now_us),
		.current_profile (current_profile),
		.current_quality (current_quality),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.new_profile     (new_profile),
		.new_quality     (new_quality),
		.profile_changed (profile_changed),
		.quality_changed (quality_changed),
		.action_taken    (action_taken)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run length guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	// Clamp a signed quality value; crossed bounds give the minimum below it, else the maximum.
	function automatic logic [6:0] bound_quality(input int q);
		if (q < int'(settings.quality_min))
			return settings.quality_min;
		if (q > int'(settings.quality_max))
			return settings.quality_max;
		return q[6:0];
	endfunction

	// Decide one tick and advance the shift times as the block does.
	function automatic verdict_t govern_tick(input tick_t t);
		verdict_t    v;
		logic [31:0] backlog;
		logic        busy_now;
		logic        quiet_now;
		logic [63:0] since_down;
		logic [63:0] since_up;
		backlog = (t.frames_accepted > t.frames_served) ?
			t.frames_accepted - t.frames_served : 32'd0;
		busy_now = (t.cpu_load > settings.cpu_high_pct) || (backlog > settings.backlog_high);
		quiet_now = (t.cpu_load < settings.cpu_low_pct) && (backlog < settings.backlog_low);
		since_down = t.time_now_us - last_down_us;
		since_up = t.time_now_us - last_up_us;
		v.new_profile = t.current_profile;
		v.new_quality = t.current_quality;
		v.action = ACT_NONE;
		if (busy_now) begin
			if (t.current_profile == PROF_720) begin
				v.new_profile = PROF_480;
				v.action = ACT_PROF_DOWN;
				last_down_us = t.time_now_us;
			end else if (t.current_profile == PROF_480) begin
				v.new_profile = PROF_240;
				v.action = ACT_PROF_DOWN;
				last_down_us = t.time_now_us;
			end else begin
				v.new_quality = bound_quality(int'(t.current_quality) -
					int'(settings.quality_step));
				v.action = ACT_Q_DOWN;
			end
		end else if (quiet_now && since_down > settings.guard_time_us &&
				since_up > settings.guard_time_us) begin
			if (t.current_profile == PROF_240) begin
				v.new_profile = PROF_480;
				v.action = ACT_PROF_UP;
				last_up_us = t.time_now_us;
			end else if (t.current_profile == PROF_480) begin
				v.new_profile = PROF_720;
				v.action = ACT_PROF_UP;
				last_up_us = t.time_now_us;
			end else begin
				v.new_quality = bound_quality(int'(t.current_quality) +
					int'(settings.quality_step));
				v.action = ACT_Q_UP;
			end
		end
		v.profile_changed = (v.new_profile != t.current_profile);
		v.quality_changed = (v.new_quality != t.current_quality);
		return v;
	endfunction

	// Predict a verdict for every item the block accepts.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			pending_verdicts.push_back(govern_tick({cpu_load, frames_accepted, frames_served,
				time_now_us, current_profile, current_quality}));
		end
	end

	// Compare every accepted result item with the oldest prediction.
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$error("result item with no prediction waiting");
				mismatches = mismatches + 1;
			end else begin
				v = pending_verdicts.pop_front();
				if (new_profile !== v.new_profile) begin
					$error("new_profile: expected %0d, actual %0d", v.new_profile, new_profile);
					mismatches = mismatches + 1;
				end
				if (new_quality !== v.new_quality) begin
					$error("new_quality: expected %0d, actual %0d", v.new_quality, new_quality);
					mismatches = mismatches + 1;
				end
				if (profile_changed !== v.profile_changed) begin
					$error("profile_changed: expected %0d, actual %0d", v.profile_changed,
						profile_changed);
					mismatches = mismatches + 1;
				end
				if (quality_changed !== v.quality_changed) begin
					$error("quality_changed: expected %0d, actual %0d", v.quality_changed,
						quality_changed);
					mismatches = mismatches + 1;
				end
				if (action_taken !== v.action) begin
					$error("action_taken: expected %0d, actual %0d", v.action, action_taken);
					mismatches = mismatches + 1;
				end
			end
		end
	end

	// Receiver back-pressure: short stall and free bursts, long free stretches and a few long stalls.
	initial begin
		int unsigned hold;
		int unsigned pick;
		logic        level;
		hold = 0;
		level = 1'b0;
		forever begin
			@(posedge clk);
			if (hold == 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					level = 1'b0;
					hold = $urandom_range(1, 3);
				end else if (pick < 80) begin
					level = 1'b1;
					hold = $urandom_range(1, 3);
				end else if (pick < 92) begin
					level = 1'b0;
					hold = $urandom_range(20, 80);
				end else begin
					level = 1'b1;
					hold = $urandom_range(10, 40);
				end
			end
			out_stall <= level;
			hold = hold - 1;
		end
	end

	// Idle cycles before the next item: mostly none or a few, sometimes many.
	function automatic int pick_gap();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (calm_left > 0) begin
			calm_left = calm_left - 1;
			return 0;
		end
		if (pick < 5) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Present one item and hold it until the block takes it; valid stays high afterwards.
	task automatic send_tick(input logic [7:0] load, input logic [31:0] acc,
			input logic [31:0] srv, input logic [63:0] stamp, input logic [1:0] prof,
			input logic [6:0] qual);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cpu_load <= load;
		frames_accepted <= acc;
		frames_served <= srv;
		time_now_us <= stamp;
		current_profile <= prof;
		current_quality <= qual;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Stop sending and wait until every predicted result item has come back.
	task automatic settle_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one register and keep the mirror in step, masked to the register's width.
	task automatic program_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_CPU_HIGH: settings.cpu_high_pct = data[6:0];
			REG_CPU_LOW:  settings.cpu_low_pct = data[6:0];
			REG_BL_HIGH:  settings.backlog_high = data[7:0];
			REG_BL_LOW:   settings.backlog_low = data[7:0];
			REG_GUARD:    settings.guard_time_us = data;
			REG_Q_MIN:    settings.quality_min = data[6:0];
			REG_Q_MAX:    settings.quality_max = data[6:0];
			REG_Q_STEP:   settings.quality_step = data[6:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic restore_defaults();
		program_reg(REG_CPU_HIGH, 32'(RST_CPU_HIGH));
		program_reg(REG_CPU_LOW, 32'(RST_CPU_LOW));
		program_reg(REG_BL_HIGH, 32'(RST_BL_HIGH));
		program_reg(REG_BL_LOW, 32'(RST_BL_LOW));
		program_reg(REG_GUARD, RST_GUARD);
		program_reg(REG_Q_MIN, 32'(RST_Q_MIN));
		program_reg(REG_Q_MAX, 32'(RST_Q_MAX));
		program_reg(REG_Q_STEP, 32'(RST_Q_STEP));
	endtask

	// Random ticks: mostly a steady clock and loads near the thresholds, the rest noise.
	task automatic random_ticks(input int count);
		int unsigned pick;
		logic [7:0]  load;
		logic [31:0] acc;
		logic [31:0] srv;
		logic [63:0] stamp;
		logic [1:0]  prof;
		logic [6:0]  qual;
		for (int i = 0; i < count; i++) begin
			prof = 2'($urandom_range(0, 3));
			qual = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 100)) :
				7'($urandom_range(0, 127));
			if ($urandom_range(0, 99) < 80) begin
				stim_time_us = stim_time_us +
					({32'd0, settings.guard_time_us} * 64'($urandom_range(0, 4))) / 64'd2 +
					64'($urandom_range(0, 2));
				stamp = stim_time_us;
				pick = $urandom_range(0, 9);
				if (pick < 4)
					load = (settings.cpu_low_pct > 0) ?
						8'($urandom_range(0, int'(settings.cpu_low_pct) - 1)) : 8'd0;
				else if (pick < 6)
					load = 8'($urandom_range(settings.cpu_low_pct, settings.cpu_high_pct));
				else if (pick < 8)
					load = 8'(int'(settings.cpu_high_pct) + int'($urandom_range(0, 3)));
				else
					load = 8'($urandom_range(0, 255));
				acc = $urandom;
				pick = $urandom_range(0, 3);
				if (pick < 2)
					srv = acc - $urandom_range(0, settings.backlog_low);
				else if (pick == 2)
					srv = acc - $urandom_range(settings.backlog_low,
						int'(settings.backlog_high) + 2);
				else
					srv = acc + $urandom_range(0, 5);
			end else begin
				load = 8'($urandom);
				acc = $urandom;
				srv = $urandom;
				stamp = {$urandom, $urandom};
				if ($urandom_range(0, 1) == 1)
					stim_time_us = stamp;
			end
			send_tick(load, acc, srv, stamp, prof, qual);
		end
	endtask

	// Defaults after reset: every rung up and down, guard boundaries and quality clamping.
	task automatic test_default_decisions();
		send_tick(8'd0, 32'd0, 32'd0, 64'd0, PROF_240, 7'd0);
		send_tick(8'd255, 32'd0, 32'd0, 64'd1, PROF_720, 7'd127);
		send_tick(8'd255, 32'd0, 32'd0, 64'd2, PROF_480, 7'd60);
		send_tick(8'd255, 32'd0, 32'd0, 64'd3, PROF_240, 7'd52);
		send_tick(8'd255, 32'd0, 32'd0, 64'd4, 2'd3, 7'd127);
		send_tick(8'd0, 32'd10, 32'd2, 64'd5, PROF_240, 7'd70);
		send_tick(8'd0, 32'hFFFF_FFFF, 32'd0, 64'd2, PROF_720, 7'd70);
		// Exactly the guard time since the last downshift is not enough.
		send_tick(8'd0, 32'd0, 32'hFFFF_FFFF, 64'd10_000_002, PROF_240, 7'd70);
		send_tick(8'd0, 32'd0, 32'd0, 64'd10_000_003, PROF_240, 7'd70);
		send_tick(8'd0, 32'd1, 32'd0, 64'd20_000_003, PROF_480, 7'd70);
		send_tick(8'd54, 32'd1, 32'd0, 64'd20_000_004, PROF_480, 7'd70);
		send_tick(8'd0, 32'd0, 32'd0, 64'd30_000_005, PROF_720, 7'd88);
		// A quality step that the clamp cancels still reports its action.
		send_tick(8'd0, 32'd0, 32'd0, 64'd40_000_006, 2'd3, 7'd90);
		send_tick(8'd55, 32'd0, 32'd0, 64'd60_000_000, PROF_240, 7'd100);
		send_tick(8'd85, 32'd3, 32'd0, 64'd70_000_000, PROF_720, 7'd100);
	endtask

	// Elapsed time taken modulo the width of the time stamp.
	task automatic test_time_wrap();
		send_tick(8'd200, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFF0, PROF_720, 7'd60);
		send_tick(8'd0, 32'd0, 32'd0, 64'd5, PROF_240, 7'd60);
		send_tick(8'd0, 32'd0, 32'd0, 64'd20_000_000, PROF_240, 7'd60);
		send_tick(8'd0, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, PROF_480, 7'd60);
	endtask

	// Crossed clamp bounds, a zero step and the largest step.
	task automatic test_clamp_corners();
		settle_block();
		program_reg(REG_Q_MIN, 32'd80);
		program_reg(REG_Q_MAX, 32'd40);
		program_reg(REG_Q_STEP, 32'd0);
		send_tick(8'd255, 32'd0, 32'd0, 64'd100, PROF_240, 7'd60);
		send_tick(8'd255, 32'd0, 32'd0, 64'd101, 2'd3, 7'd100);
		settle_block();
		program_reg(REG_Q_MIN, 32'd0);
		program_reg(REG_Q_MAX, 32'd127);
		program_reg(REG_Q_STEP, 32'd127);
		program_reg(REG_GUARD, 32'd0);
		send_tick(8'd255, 32'd0, 32'd0, 64'd200, 2'd3, 7'd0);
		send_tick(8'd0, 32'd0, 32'd0, 64'h8000_0000_0000_0000, 2'd3, 7'd127);
		send_tick(8'd0, 32'd0, 32'd0, 64'h8000_0000_0000_0001, PROF_720, 7'd1);
	endtask

	// Random phases under the defaults with a short guard, random settings and crossed bounds.
	task automatic test_random_sweep();
		settle_block();
		restore_defaults();
		program_reg(REG_GUARD, 32'd1000);
		random_ticks(250);
		for (int phase = 0; phase < 2; phase++) begin
			settle_block();
			program_reg(REG_CPU_HIGH, $urandom_range(0, 100));
			program_reg(REG_CPU_LOW, $urandom_range(0, 100));
			program_reg(REG_BL_HIGH, $urandom_range(0, 255));
			program_reg(REG_BL_LOW, $urandom_range(0, 255));
			program_reg(REG_GUARD, $urandom_range(0, 5000));
			program_reg(REG_Q_MIN, $urandom_range(0, 100));
			program_reg(REG_Q_MAX, $urandom_range(0, 100));
			program_reg(REG_Q_STEP, $urandom_range(0, 100));
			random_ticks(200);
		end
		settle_block();
		program_reg(REG_Q_MIN, 32'd90);
		program_reg(REG_Q_MAX, 32'd30);
		program_reg(REG_Q_STEP, 32'd20);
		random_ticks(100);
	endtask

	// Every register at zero, then all but quality_min at their largest; unused write bits set.
	task automatic test_register_extremes();
		settle_block();
		program_reg(REG_CPU_HIGH, 32'd0);
		program_reg(REG_CPU_LOW, 32'd0);
		program_reg(REG_BL_HIGH, 32'd0);
		program_reg(REG_BL_LOW, 32'd0);
		program_reg(REG_GUARD, 32'd0);
		program_reg(REG_Q_MIN, 32'd0);
		program_reg(REG_Q_MAX, 32'd0);
		program_reg(REG_Q_STEP, 32'd0);
		random_ticks(150);
		settle_block();
		program_reg(REG_CPU_HIGH, 32'hFFFF_FFFF);
		program_reg(REG_CPU_LOW, 32'hFFFF_FFFF);
		program_reg(REG_BL_HIGH, 32'hFFFF_FFFF);
		program_reg(REG_BL_LOW, 32'hFFFF_FFFF);
		program_reg(REG_GUARD, 32'hFFFF_FFFF);
		program_reg(REG_Q_MIN, 32'hFFFF_FF80);
		program_reg(REG_Q_MAX, 32'hFFFF_FFFF);
		program_reg(REG_Q_STEP, 32'hFFFF_FFFF);
		random_ticks(150);
	endtask

	// Reset once, run each test in turn, then report.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_decisions();
		test_time_wrap();
		test_clamp_corners();
		test_random_sweep();
		test_register_extremes();
		settle_block();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
